FILE: sv/swg_pkg.sv
`default_nettype none

package swg_pkg;

	// Default values of the top-level parameters.
	localparam int DEF_SAMPLE_BITS         = 8;
	localparam int DEF_MAX_PERIOD          = 256;
	localparam int DEF_TICKS_PER_SAMPLE    = 2;
	localparam int DEF_QUARTER_TABLE_DEPTH = 1024;

	// Phase is a 16-bit fraction of a turn: two quadrant bits and a remainder.
	localparam int PHASE_W    = 16;
	localparam int QUADRANT_W = 2;
	localparam int REM_W      = PHASE_W - QUADRANT_W;
	localparam int PHASE_TURN = 1 << PHASE_W;
	localparam int STEP_W     = 15;

	// Sample clock divider: integer part plus a fraction in 1/256 units.
	localparam int DIV_INT_W  = 16;
	localparam int DIV_FRAC_W = 8;
	localparam int DIV_W      = DIV_INT_W + DIV_FRAC_W;

	localparam int PERIOD_FLOOR = 4;
	localparam int QUEUE_DEPTH  = 2;

	// Configuration write channel.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SAMPLES_PER_PERIOD = 2'd0,
		REG_PHASE_STEP         = 2'd1,
		REG_DIVIDER_INTEGER    = 2'd2,
		REG_DIVIDER_FRACTION   = 2'd3
	} cfg_reg_t;

	// Fixed-point constants of the sine table.
	localparam logic [63:0] ONE_Q30     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

endpackage

`default_nettype wire

FILE: sv/swg_tick_if.sv
`default_nettype none

interface swg_tick_if;
	logic valid;
	logic ready;
	logic tick_enable;

	modport source (output valid, output tick_enable, input ready);
	modport sink   (input valid, input tick_enable, output ready);
endinterface

`default_nettype wire

FILE: sv/swg_cfg_if.sv
`default_nettype none

interface swg_cfg_if import swg_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/swg_sample_if.sv
`default_nettype none

interface swg_sample_if #(
	parameter int SAMPLE_BITS = 8,
	parameter int POS_W       = 8
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] dac_level;
	logic [POS_W-1:0]       sample_position;
	logic                   new_sample;
	logic                   period_start;

	modport source (output valid, output dac_level, output sample_position,
		output new_sample, output period_start, input ready);
	modport sink   (input valid, input dac_level, input sample_position,
		input new_sample, input period_start, output ready);
endinterface

`default_nettype wire

FILE: sv/swg_job_if.sv
`default_nettype none

interface swg_job_if import swg_pkg::*; #(
	parameter int POS_W = 8
);
	logic               valid;
	logic               ready;
	logic               new_sample;
	logic               period_start;
	logic [POS_W-1:0]   sample_position;
	logic [PHASE_W-1:0] phase;

	modport source (output valid, output new_sample, output period_start,
		output sample_position, output phase, input ready);
	modport sink   (input valid, input new_sample, input period_start,
		input sample_position, input phase, output ready);
endinterface

`default_nettype wire

FILE: sv/sine_table_waveform_generator_unit.sv
// Channel   Dir  Payload                                               Transfer
// tick      in   tick_enable                                           valid & ready
// cfg       in   index (register number), data                         valid & ready
// sample    out  dac_level, sample_position, new_sample, period_start  valid & ready
//
// One tick transaction is accepted per clock while tick ready is high. Its result passes
// the queue and two back stages, three registers in all, before it is offered.
// The rate is set by the front stage, which updates the tick accumulator, sample
// index and phase for each accepted tick.
// Reset clears all counters and sets the level to mid-scale; the sine table is constant.
// A stalled sample channel fills the output stages and a two-entry queue before tick
// ready drops; the configuration channel is always ready.
`default_nettype none

module sine_table_waveform_generator_unit import swg_pkg::*; #(
	parameter int SAMPLE_BITS         = DEF_SAMPLE_BITS,
	parameter int MAX_PERIOD          = DEF_MAX_PERIOD,
	parameter int TICKS_PER_SAMPLE    = DEF_TICKS_PER_SAMPLE,
	parameter int QUARTER_TABLE_DEPTH = DEF_QUARTER_TABLE_DEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	swg_tick_if.sink     tick,
	swg_cfg_if.sink      cfg,
	swg_sample_if.source sample
);

	localparam int POS_W = $clog2(MAX_PERIOD);

	// The front stage works out, for each tick transaction, whether the divider
	// has run out and what the new sample index and phase are. Those decisions
	// travel as jobs through a short queue to the back stage.
	swg_job_if #(.POS_W(POS_W)) front_job ();
	swg_job_if #(.POS_W(POS_W)) back_job ();

	swg_front #(
		.MAX_PERIOD       (MAX_PERIOD),
		.TICKS_PER_SAMPLE (TICKS_PER_SAMPLE)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.cfg    (cfg),
		.job    (front_job)
	);

	// The queue lets the front keep taking ticks while the result side is stalled,
	// until both of its entries are full.
	swg_queue #(
		.POS_W (POS_W)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_ch (front_job),
		.pop_ch  (back_job)
	);

	// The back stage reads the quarter-wave table at the job's phase and holds
	// the level that is on the DAC pins until the next new sample.
	swg_back #(
		.SAMPLE_BITS         (SAMPLE_BITS),
		.MAX_PERIOD          (MAX_PERIOD),
		.QUARTER_TABLE_DEPTH (QUARTER_TABLE_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (back_job),
		.sample (sample)
	);

endmodule

`default_nettype wire

FILE: sv/swg_front.sv
`default_nettype none

module swg_front import swg_pkg::*; #(
	parameter int MAX_PERIOD       = DEF_MAX_PERIOD,
	parameter int TICKS_PER_SAMPLE = DEF_TICKS_PER_SAMPLE
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	swg_tick_if.sink    tick,
	swg_cfg_if.sink     cfg,
	swg_job_if.source   job
);

	localparam int CNT_W = $clog2(MAX_PERIOD);
	localparam int SPP_W = CNT_W + 1;
	localparam int THR_W = DIV_W + $clog2(TICKS_PER_SAMPLE + 1);
	localparam int ACC_W = THR_W + 1;
	localparam int TICK_INC = 1 << DIV_FRAC_W;

	logic [SPP_W-1:0]      spp_q;
	logic [STEP_W-1:0]     step_q;
	logic [DIV_INT_W-1:0]  div_int_q;
	logic [DIV_FRAC_W-1:0] div_frac_q;
	logic [ACC_W-1:0]      acc_q;
	logic [CNT_W-1:0]      counter_q;
	logic [PHASE_W-1:0]    phase_q;

	logic [DIV_W-1:0]   div;
	logic [THR_W-1:0]   thr;
	logic [ACC_W-1:0]   acc_inc;
	logic [SPP_W-1:0]   period;
	logic [SPP_W-1:0]   count_inc;
	logic               accepted;
	logic               advance;
	logic               wrap;
	logic [CNT_W-1:0]   counter_nxt;
	logic [PHASE_W-1:0] phase_nxt;

	// A zero integer part is taken as a divider of exactly one.
	assign div     = (div_int_q == '0) ? DIV_W'(TICK_INC) : {div_int_q, div_frac_q};
	assign thr     = THR_W'(div) * THR_W'(TICKS_PER_SAMPLE);
	assign acc_inc = acc_q + ACC_W'(TICK_INC);
	assign advance = tick.tick_enable && (acc_inc >= ACC_W'(thr));

	assign period = (spp_q < SPP_W'(PERIOD_FLOOR)) ? SPP_W'(PERIOD_FLOOR) :
		(spp_q > SPP_W'(MAX_PERIOD)) ? SPP_W'(MAX_PERIOD) : spp_q;
	assign count_inc = {1'b0, counter_q} + SPP_W'(1);
	assign wrap      = advance && (count_inc >= period);

	always_comb begin
		counter_nxt = counter_q;
		phase_nxt   = phase_q;
		if (wrap) begin
			counter_nxt = '0;
			phase_nxt   = '0;
		end else if (advance) begin
			counter_nxt = count_inc[CNT_W-1:0];
			phase_nxt   = phase_q + PHASE_W'(step_q);
		end
	end

	assign accepted   = tick.valid && tick.ready;
	assign tick.ready = job.ready;

	assign job.valid           = tick.valid;
	assign job.new_sample      = advance;
	assign job.period_start    = wrap;
	assign job.sample_position = counter_nxt;
	assign job.phase           = phase_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			counter_q <= '0;
			phase_q   <= '0;
		end else if (accepted && tick.tick_enable) begin
			acc_q     <= advance ? (acc_inc - ACC_W'(thr)) : acc_inc;
			counter_q <= counter_nxt;
			phase_q   <= phase_nxt;
		end
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spp_q      <= SPP_W'(MAX_PERIOD);
			step_q     <= STEP_W'(PHASE_TURN / MAX_PERIOD);
			div_int_q  <= DIV_INT_W'(1);
			div_frac_q <= '0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_SAMPLES_PER_PERIOD: spp_q      <= cfg.data[SPP_W-1:0];
				REG_PHASE_STEP:         step_q     <= cfg.data[STEP_W-1:0];
				REG_DIVIDER_INTEGER:    div_int_q  <= cfg.data[DIV_INT_W-1:0];
				REG_DIVIDER_FRACTION:   div_frac_q <= cfg.data[DIV_FRAC_W-1:0];
				default: ;
			endcase
		end
	end

	a_wrap_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accepted && wrap |=> (counter_q == '0) && (phase_q == '0))
		else $error("wrap did not return index and phase to zero");

	a_idle_tick_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accepted && !tick.tick_enable |=> $stable(acc_q) && $stable(counter_q)
			&& $stable(phase_q))
		else $error("disabled tick changed the sample state");

endmodule

`default_nettype wire

FILE: sv/swg_queue.sv
`default_nettype none

module swg_queue import swg_pkg::*; #(
	parameter int POS_W = 8
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	swg_job_if.sink     push_ch,
	swg_job_if.source   pop_ch
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic               new_sample_q   [QUEUE_DEPTH];
	logic               period_start_q [QUEUE_DEPTH];
	logic [POS_W-1:0]   position_q     [QUEUE_DEPTH];
	logic [PHASE_W-1:0] phase_q        [QUEUE_DEPTH];

	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ch.ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign push          = push_ch.valid && push_ch.ready;
	assign pop           = pop_ch.valid && pop_ch.ready;

	assign pop_ch.valid           = (count_q != '0);
	assign pop_ch.new_sample      = new_sample_q[rd_ptr_q];
	assign pop_ch.period_start    = period_start_q[rd_ptr_q];
	assign pop_ch.sample_position = position_q[rd_ptr_q];
	assign pop_ch.phase           = phase_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			new_sample_q[wr_ptr_q]   <= push_ch.new_sample;
			period_start_q[wr_ptr_q] <= push_ch.period_start;
			position_q[wr_ptr_q]     <= push_ch.sample_position;
			phase_q[wr_ptr_q]        <= push_ch.phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("queue fill count out of step with pushes");

endmodule

`default_nettype wire

FILE: sv/swg_back.sv
`default_nettype none

module swg_back import swg_pkg::*; #(
	parameter int SAMPLE_BITS         = DEF_SAMPLE_BITS,
	parameter int MAX_PERIOD          = DEF_MAX_PERIOD,
	parameter int QUARTER_TABLE_DEPTH = DEF_QUARTER_TABLE_DEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	swg_job_if.sink      job,
	swg_sample_if.source sample
);

	localparam int POS_W = $clog2(MAX_PERIOD);
	localparam int IDX_W = $clog2(QUARTER_TABLE_DEPTH + 1);
	localparam int ROM_W = 2 * SAMPLE_BITS;
	localparam logic [SAMPLE_BITS-1:0] MID_LEVEL =
		SAMPLE_BITS'(((1 << SAMPLE_BITS) - 1) >> 1);

	typedef logic [ROM_W-1:0] rom_arr_t [QUARTER_TABLE_DEPTH + 1];

	// sin(pi/2 * k / depth) in Q30 by a Taylor series of degree 17.
	function automatic logic [63:0] sine_q30(int unsigned k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		x    = (HALF_PI_Q30 * 64'(k)) / 64'(QUARTER_TABLE_DEPTH);
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd272; sum = sum + longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > longint'(ONE_Q30)) begin
			sum = longint'(ONE_Q30);
		end
		return 64'(sum);
	endfunction

	// Each entry holds the level below mid-scale (upper half) and above it (lower half).
	function automatic rom_arr_t build_rom();
		rom_arr_t    r;
		logic [63:0] mag;
		logic [63:0] scale;
		scale = (64'd1 << SAMPLE_BITS) - 64'd1;
		for (int k = 0; k <= QUARTER_TABLE_DEPTH; k++) begin
			mag  = (k == QUARTER_TABLE_DEPTH) ? ONE_Q30 : sine_q30(k);
			r[k] = {SAMPLE_BITS'(((ONE_Q30 - mag) * scale) >> 31),
				SAMPLE_BITS'(((ONE_Q30 + mag) * scale) >> 31)};
		end
		return r;
	endfunction

	localparam rom_arr_t LEVEL_ROM = build_rom();

	logic [REM_W-1:0]      rem;
	logic [QUADRANT_W-1:0] quadrant;
	logic [31:0]           idx_prod;
	logic [IDX_W-1:0]      idx_raw;
	logic [IDX_W-1:0]      rom_idx;
	logic                  ready_s1;
	logic                  ready_s2;
	logic                  load_s1;
	logic                  load_s2;

	logic                   valid_s1;
	logic                   new_sample_s1;
	logic                   period_start_s1;
	logic [POS_W-1:0]       position_s1;
	logic                   neg_s1;
	logic [ROM_W-1:0]       rom_s1;

	logic                   valid_s2;
	logic                   new_sample_s2;
	logic                   period_start_s2;
	logic [POS_W-1:0]       position_s2;
	logic [SAMPLE_BITS-1:0] level_s2;

	assign rem      = job.phase[REM_W-1:0];
	assign quadrant = job.phase[PHASE_W-1 -: QUADRANT_W];
	assign idx_prod = (32'(rem) * 32'(QUARTER_TABLE_DEPTH)) >> REM_W;
	assign idx_raw  = idx_prod[IDX_W-1:0];
	// Odd quadrants run the quarter table backwards.
	assign rom_idx  = quadrant[0] ? (IDX_W'(QUARTER_TABLE_DEPTH) - idx_raw) : idx_raw;

	assign ready_s2  = !valid_s2 || sample.ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign job.ready = ready_s1;
	assign load_s1   = ready_s1 && job.valid;
	assign load_s2   = ready_s2 && valid_s1;

	always_ff @(posedge clk) begin
		if (load_s1) begin
			new_sample_s1   <= job.new_sample;
			period_start_s1 <= job.period_start;
			position_s1     <= job.sample_position;
			neg_s1          <= quadrant[1];
			rom_s1          <= LEVEL_ROM[rom_idx];
		end
		if (load_s2) begin
			new_sample_s2   <= new_sample_s1;
			period_start_s2 <= period_start_s1;
			position_s2     <= position_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			level_s2 <= MID_LEVEL;
		end else begin
			if (ready_s1) begin
				valid_s1 <= job.valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (load_s2 && new_sample_s1) begin
				level_s2 <= neg_s1 ? rom_s1[ROM_W-1 -: SAMPLE_BITS]
					: rom_s1[SAMPLE_BITS-1:0];
			end
		end
	end

	assign sample.valid           = valid_s2;
	assign sample.dac_level       = level_s2;
	assign sample.sample_position = position_s2;
	assign sample.new_sample      = new_sample_s2;
	assign sample.period_start    = period_start_s2;

	a_level_hold: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 && !new_sample_s1 |=> $stable(level_s2))
		else $error("level changed without a new sample");

	a_wrap_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.period_start |->
			(sample.sample_position == '0) && sample.new_sample)
		else $error("period start reported away from sample zero");

endmodule

`default_nettype wire

FILE: tb/sine_table_waveform_generator_unit_tb.sv
`default_nettype none

module sine_table_waveform_generator_unit_tb;
	import swg_pkg::*;

	// Widths and sizes follow the default parameters that the unit is built with.
	localparam int LEVEL_BITS    = DEF_SAMPLE_BITS;
	localparam int POS_BITS      = $clog2(DEF_MAX_PERIOD);
	localparam int TABLE_DEPTH   = DEF_QUARTER_TABLE_DEPTH;
	localparam int RANDOM_TICKS  = 1750;
	localparam int IDLE_PCT      = 30;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS   = 40;

	// One result transaction as the sample channel presents it.
	typedef struct packed {
		logic [LEVEL_BITS-1:0] level;
		logic [POS_BITS-1:0]   position;
		logic                  fresh;
		logic                  wrapped;
	} dac_result_t;

	logic clk;
	logic arst_n;

	swg_tick_if tick_ch ();
	swg_cfg_if cfg_ch ();
	swg_sample_if #(.SAMPLE_BITS(LEVEL_BITS), .POS_W(POS_BITS)) sample_ch ();

	sine_table_waveform_generator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.cfg    (cfg_ch),
		.sample (sample_ch)
	);

	// The clock starts low, so the first rising edge falls at five time units.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Tick-enable values waiting to be offered, and the results that the
	// generator model says the unit owes us, oldest first.
	bit          pending_ticks[$];
	dac_result_t dac_forecast[$];

	// Model copy of the configuration registers.
	logic [8:0]  period_reg;
	logic [14:0] step_reg;
	logic [15:0] div_int_reg;
	logic [7:0]  div_frac_reg;

	// Model copy of the running state. The tick accumulator is kept wide
	// enough for the largest divider times the ticks per sample.
	int unsigned       tick_acc;
	int unsigned       sample_idx;
	logic [15:0]       phase_acc;
	logic [LEVEL_BITS-1:0] level_reg;
	longint unsigned   sine_q30[0:TABLE_DEPTH];

	bit          no_stall;
	bit          tick_taken;
	int unsigned error_count;
	int unsigned ticks_accepted;
	int unsigned ticks_enabled;
	int unsigned reg_writes;
	int unsigned advances_seen;
	int unsigned wraps_seen;

	// Quarter-wave entry k holds sin(pi/2 * k / depth) in Q30, built from
	// a Taylor series up to the seventeenth power and clamped to 0..1.
	function automatic longint unsigned taylor_sine(int unsigned k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		x = (HALF_PI_Q30 * 64'(k)) / 64'(TABLE_DEPTH);
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int unsigned n = 1; n <= 8; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n[0])
				sum -= longint'(term);
			else
				sum += longint'(term);
		end
		if (sum < 0)
			sum = 0;
		if (sum > longint'(ONE_Q30))
			sum = longint'(ONE_Q30);
		return longint'(sum);
	endfunction

	// Level for a phase: the quadrant picks mirroring and sign, and the
	// result is scaled from Q30 around mid-scale to the DAC width.
	function automatic logic [LEVEL_BITS-1:0] level_at(logic [15:0] ph);
		logic [1:0]      quad;
		int unsigned     idx;
		longint unsigned mag;
		longint unsigned base;
		quad = ph[15:14];
		idx = (int'(ph[13:0]) * TABLE_DEPTH) >> 14;
		if (quad[0])
			idx = TABLE_DEPTH - idx;
		mag = sine_q30[idx];
		base = quad[1] ? ONE_Q30 - mag : ONE_Q30 + mag;
		return LEVEL_BITS'((base * ((64'd1 << LEVEL_BITS) - 1)) >> 31);
	endfunction

	function automatic void reset_generator();
		for (int unsigned k = 0; k < TABLE_DEPTH; k++)
			sine_q30[k] = taylor_sine(k);
		sine_q30[TABLE_DEPTH] = ONE_Q30;
		period_reg = 9'd256;
		step_reg = 15'd256;
		div_int_reg = 16'd1;
		div_frac_reg = 8'd0;
		tick_acc = 0;
		sample_idx = 0;
		phase_acc = 16'd0;
		level_reg = level_at(16'd0);
	endfunction

	function automatic void apply_register(cfg_reg_t which, logic [CFG_DATA_W-1:0] value);
		case (which)
			REG_SAMPLES_PER_PERIOD: period_reg = value[8:0];
			REG_PHASE_STEP:         step_reg = value[14:0];
			REG_DIVIDER_INTEGER:    div_int_reg = value[15:0];
			REG_DIVIDER_FRACTION:   div_frac_reg = value[7:0];
			default: ;
		endcase
	endfunction

	// One system tick of the generator. A zero integer part means a divider
	// of exactly one; the period is clamped to its legal range when used, and
	// an index beyond a freshly shrunk period wraps on the next sample.
	function automatic dac_result_t advance_generator(bit enabled);
		dac_result_t r;
		int unsigned divisor;
		int unsigned threshold;
		int unsigned span;
		r.fresh = 1'b0;
		r.wrapped = 1'b0;
		if (enabled) begin
			divisor = (div_int_reg == 16'd0) ? 256 : {div_int_reg, div_frac_reg};
			threshold = divisor * DEF_TICKS_PER_SAMPLE;
			tick_acc += 256;
			// A surplus left by a larger divider drains one threshold per tick.
			if (tick_acc >= threshold) begin
				tick_acc -= threshold;
				r.fresh = 1'b1;
				span = period_reg;
				if (span < PERIOD_FLOOR)
					span = PERIOD_FLOOR;
				if (span > DEF_MAX_PERIOD)
					span = DEF_MAX_PERIOD;
				if (sample_idx + 1 >= span) begin
					sample_idx = 0;
					phase_acc = 16'd0;
					r.wrapped = 1'b1;
				end else begin
					sample_idx++;
					phase_acc = phase_acc + 16'(step_reg);
				end
				level_reg = level_at(phase_acc);
			end
		end
		r.level = level_reg;
		r.position = POS_BITS'(sample_idx);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t: mismatch: %s", $time, msg);
	endtask

	// Driver. Inputs move only at the falling edge. A tick transaction that
	// is on offer stays on offer until it has been taken; both the sender and
	// the sample receiver hold off at random unless a steady stretch is on.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!tick_ch.valid || tick_taken) begin
				if (pending_ticks.size() > 0 &&
						(no_stall || $urandom_range(99) >= IDLE_PCT)) begin
					tick_ch.valid <= 1'b1;
					tick_ch.tick_enable <= pending_ticks.pop_front();
				end else begin
					tick_ch.valid <= 1'b0;
				end
			end
			sample_ch.ready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Monitor. At each rising edge it applies accepted register writes to the
	// model, predicts the result of each accepted tick transaction, and checks
	// each accepted sample transaction against the oldest prediction.
	always @(posedge clk) begin
		dac_result_t got;
		dac_result_t want;
		if (arst_n) begin
			tick_taken <= tick_ch.valid && tick_ch.ready;
			if (cfg_ch.valid && cfg_ch.ready)
				apply_register(cfg_reg_t'(cfg_ch.index), cfg_ch.data);
			if (tick_ch.valid && tick_ch.ready) begin
				ticks_accepted++;
				dac_forecast.push_back(advance_generator(tick_ch.tick_enable));
			end
			if (sample_ch.valid && sample_ch.ready) begin
				got.level = sample_ch.dac_level;
				got.position = sample_ch.sample_position;
				got.fresh = sample_ch.new_sample;
				got.wrapped = sample_ch.period_start;
				if (dac_forecast.size() == 0) begin
					report_mismatch($sformatf("sample level %0d position %0d with none expected",
						got.level, got.position));
				end else begin
					want = dac_forecast.pop_front();
					if (got.level !== want.level)
						report_mismatch($sformatf("dac_level %0d, expected %0d",
							got.level, want.level));
					if (got.position !== want.position)
						report_mismatch($sformatf("sample_position %0d, expected %0d",
							got.position, want.position));
					if (got.fresh !== want.fresh)
						report_mismatch($sformatf("new_sample %0b, expected %0b",
							got.fresh, want.fresh));
					if (got.wrapped !== want.wrapped)
						report_mismatch($sformatf("period_start %0b, expected %0b",
							got.wrapped, want.wrapped));
					if (want.fresh)
						advances_seen++;
					if (want.wrapped)
						wraps_seen++;
				end
			end
		end
	end

	task automatic push_tick(bit enabled);
		pending_ticks.push_back(enabled);
		if (enabled)
			ticks_enabled++;
	endtask

	task automatic run_ticks(int unsigned count, int unsigned enable_pct);
		for (int unsigned i = 0; i < count; i++)
			push_tick($urandom_range(99) < enable_pct);
	endtask

	// Hold the sender until every tick has gone in and every owed result has
	// come out, then give the pipeline time to settle.
	task automatic wait_quiet();
		while (pending_ticks.size() != 0 || tick_ch.valid)
			@(posedge clk);
		while (dac_forecast.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The bits above a register's width carry random values, which the unit
	// must ignore.
	task automatic write_reg(cfg_reg_t which, int unsigned value, int unsigned used);
		int unsigned mask;
		mask = (used >= 32) ? 32'hFFFF_FFFF : ((32'd1 << used) - 1);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= which;
		cfg_ch.data <= CFG_DATA_W'(($urandom & ~mask) | (value & mask));
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		reg_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic random_setting();
		int unsigned pick;
		if ($urandom_range(3) != 0) begin
			pick = $urandom_range(9);
			if (pick < 6)
				write_reg(REG_SAMPLES_PER_PERIOD, $urandom_range(4, 32), 9);
			else if (pick < 8)
				write_reg(REG_SAMPLES_PER_PERIOD, $urandom_range(33, 256), 9);
			else if (pick == 8)
				write_reg(REG_SAMPLES_PER_PERIOD, $urandom_range(0, 3), 9);
			else
				write_reg(REG_SAMPLES_PER_PERIOD, $urandom_range(257, 511), 9);
		end
		if ($urandom_range(3) != 0) begin
			if ($urandom_range(1))
				write_reg(REG_PHASE_STEP, $urandom_range(256, 16384), 15);
			else
				write_reg(REG_PHASE_STEP, $urandom_range(0, 32767), 15);
		end
		if ($urandom_range(3) != 0) begin
			pick = $urandom_range(9);
			if (pick < 7)
				write_reg(REG_DIVIDER_INTEGER, $urandom_range(1, 3), 16);
			else if (pick == 7)
				write_reg(REG_DIVIDER_INTEGER, 0, 16);
			else
				write_reg(REG_DIVIDER_INTEGER, $urandom_range(4, 40), 16);
		end
		if ($urandom_range(3) != 0)
			write_reg(REG_DIVIDER_FRACTION, $urandom_range(0, 255), 8);
	endtask

	initial begin
		int unsigned scenario;
		int unsigned phase_no;
		arst_n = 1'b0;
		tick_ch.valid = 1'b0;
		tick_ch.tick_enable = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_SAMPLES_PER_PERIOD;
		cfg_ch.data = '0;
		sample_ch.ready = 1'b0;
		tick_taken = 1'b0;
		no_stall = 1'b0;
		reset_generator();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part. First the reset setting, with disabled ticks mixed in
		// so that one can see them leave every output alone.
		push_tick(1'b0);
		push_tick(1'b1);
		push_tick(1'b1);
		push_tick(1'b0);
		push_tick(1'b1);
		wait_quiet();

		// A period below the floor, a zero integer divider with a full
		// fraction (which must count as exactly one), and a quarter-turn step.
		write_reg(REG_SAMPLES_PER_PERIOD, 0, 9);
		write_reg(REG_PHASE_STEP, 16384, 15);
		write_reg(REG_DIVIDER_INTEGER, 0, 16);
		write_reg(REG_DIVIDER_FRACTION, 255, 8);
		run_ticks(8, 100);
		wait_quiet();

		// A period above the ceiling and the largest step, so the phase wraps
		// round the turn, with a half fraction on a divider of one.
		write_reg(REG_SAMPLES_PER_PERIOD, 511, 9);
		write_reg(REG_PHASE_STEP, 32767, 15);
		write_reg(REG_DIVIDER_INTEGER, 1, 16);
		write_reg(REG_DIVIDER_FRACTION, 128, 8);
		run_ticks(8, 100);
		wait_quiet();

		// The largest divider: nothing advances for a very long time.
		write_reg(REG_DIVIDER_INTEGER, 65535, 16);
		write_reg(REG_DIVIDER_FRACTION, 255, 8);
		run_ticks(4, 100);
		wait_quiet();

		// Random part. Most phases take a random setting; some build up a
		// large count under a big divider and then shrink it, and some run an
		// index far up a long period before shrinking the period beneath it.
		phase_no = 0;
		while (ticks_accepted < RANDOM_TICKS) begin
			no_stall = (phase_no >= 8 && phase_no < 13);
			scenario = $urandom_range(9);
			if (scenario == 0) begin
				write_reg(REG_DIVIDER_INTEGER, $urandom_range(200, 65535), 16);
				run_ticks($urandom_range(60, 150), 100);
				wait_quiet();
				write_reg(REG_DIVIDER_INTEGER, 1, 16);
				write_reg(REG_DIVIDER_FRACTION, 0, 8);
				run_ticks(100, 100);
			end else if (scenario == 1) begin
				write_reg(REG_SAMPLES_PER_PERIOD, 256, 9);
				write_reg(REG_DIVIDER_INTEGER, 1, 16);
				write_reg(REG_DIVIDER_FRACTION, 0, 8);
				run_ticks(120, 100);
				wait_quiet();
				write_reg(REG_SAMPLES_PER_PERIOD, $urandom_range(4, 16), 9);
				run_ticks(30, 100);
			end else begin
				random_setting();
				run_ticks($urandom_range(20, 80), 85);
			end
			wait_quiet();
			phase_no++;
		end
		no_stall = 1'b0;

		if (dac_forecast.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", dac_forecast.size()));
		$display("Covered %0d tick transactions (%0d enabled) and %0d register writes.",
			ticks_accepted, ticks_enabled, reg_writes);
		$display("Checked %0d sample advances and %0d period wraps; %0d mismatches.",
			advances_seen, wraps_seen, error_count);
		if (error_count == 0)
			$display("sine_table_waveform_generator_unit_tb: done, clean");
		else
			$display("sine_table_waveform_generator_unit_tb: done, errors");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run, including every stall.
	initial begin
		#5000000;
		$display("sine_table_waveform_generator_unit_tb: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
